[rtl/shfr_pkg.sv]
// Package for the serial HID frame receiver: result kinds, line tokens,
// request codes and the command descriptor passed from the parser to the emitter.
// No dependencies.
package shfr_pkg;

    // Request selectors on the input channel
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_FAIL    = 3'd3;
    localparam logic [2:0] KIND_SYNC    = 3'd4;
    localparam logic [2:0] KIND_RETRACT = 3'd5;

    // Line tokens
    localparam logic [7:0] TOK_SYNC     = 8'h16;
    localparam logic [7:0] TOK_SYNC_OFF = 8'h18;
    localparam logic [7:0] TOK_ACK      = 8'h06;
    localparam logic [7:0] TOK_NAK      = 8'h15;
    localparam logic [3:0] FLAG_LAST    = 4'h8;
    localparam logic [3:0] TYPE_NOTIFY  = 4'h5;

    // One parser transaction worth of results: data bytes, optional reply,
    // optional final status.
    typedef struct packed {
        logic [3:0]  ndata;
        logic        rep_en;
        logic [7:0]  rep_val;
        logic        fin_en;
        logic [2:0]  fin_kind;
        logic [7:0]  fin_val;
        logic [15:0] fin_count;
    } shfr_cmd_t;

endpackage

[rtl/serial_hid_frame_receiver.sv]
// Serial HID frame receiver: top level joining parser, descriptor queue
// and result emitter. Depends on shfr_pkg, shfr_front, shfr_queue, shfr_back.
//
// Usage:
//   s_* stream carries requests: s_tuser selects start, line byte or timeout
//   tick; s_tdata carries the line byte and the expected payload length.
//   m_* stream carries results: m_tuser is the result kind, m_tdata the value
//   and the delivered byte count, m_tlast marks the last result of a request.
//   cfg_* writes the retry limit (4 bits, 3 after reset); write it only while
//   no results are pending.
// Throughput: one request transaction per cycle while the descriptor queue
//   has room. Results leave one per cycle while m_tready is high; a good
//   frame yields up to FRAME_MAX + 2 results, so the result emitter sets
//   the sustained rate. Path: the first result of a request is written to
//   the queue with the request transaction, then to the output register,
//   and only then shows on m_tvalid.
// Reset: parser idle, retry limit 3, queue empty, no result valid.
// Stall: when m_tready is low the output register holds its result; the
//   queue keeps taking descriptors until full, then s_tready drops.
module serial_hid_frame_receiver #(
    parameter int FRAME_MAX  = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] rx_byte, [23:8] expected_len
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] value, [23:8] byte_count
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // last result of the request
    // Retry limit write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // [3:0] max_retries
);
    import shfr_pkg::*;

    localparam int QW = $bits(shfr_cmd_t) + FRAME_MAX * 8;

    logic [3:0]             max_retries_reg;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    shfr_cmd_t              push_cmd;
    logic [FRAME_MAX*8-1:0] push_frame;
    logic [QW-1:0]          head_word;
    shfr_cmd_t              head_cmd;
    logic [FRAME_MAX*8-1:0] head_frame;
    logic [7:0]             res_value;
    logic [15:0]            res_count;

    // Accept configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= 4'd3;
        end else if (cfg_valid) begin
            max_retries_reg <= cfg_data;
        end
    end

    // Parse requests and build one descriptor per request with results
    shfr_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .clk          (aclk),
        .rstn         (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser),
        .rx_byte      (s_tdata[7:0]),
        .expected_len (s_tdata[23:8]),
        .max_retries  (max_retries_reg),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd),
        .frame_data   (push_frame)
    );

    // Hold descriptors, frame bytes included, so the parser can run ahead
    shfr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (push),
        .push_data ({push_cmd, push_frame}),
        .pop       (pop),
        .head_data (head_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_cmd   = head_word[QW-1 -: $bits(shfr_cmd_t)];
    assign head_frame = head_word[FRAME_MAX*8-1:0];

    // Expand descriptors into result transactions
    shfr_back #(
        .FRAME_MAX (FRAME_MAX)
    ) u_back (
        .clk        (aclk),
        .rstn       (aresetn),
        .head_valid (!q_empty),
        .head_cmd   (head_cmd),
        .head_data  (head_frame),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_value  (res_value),
        .out_count  (res_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {res_count, res_value};

endmodule

[rtl/shfr_front.sv]
// Frame parser front end: accepts requests, tracks the transfer and frame
// state, and pushes one result descriptor per transaction that yields results.
// Depends on shfr_pkg.
module shfr_front #(
    parameter int FRAME_MAX = 8
) (
    input  logic                     clk,
    input  logic                     rstn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic [7:0]               rx_byte,
    input  logic [15:0]              expected_len,
    input  logic [3:0]               max_retries,
    input  logic                     q_full,
    output logic                     push,
    output shfr_pkg::shfr_cmd_t      cmd,
    output logic [FRAME_MAX*8-1:0]   frame_data
);
    import shfr_pkg::*;

    localparam int IDX_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [3:0]  size_reg, size_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [3:0]  retry_reg, retry_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] del_reg, del_next;
    logic [7:0]  store_reg [FRAME_MAX];

    logic        accept;
    logic        store_we;
    logic [3:0]  rc_inc;
    logic [3:0]  limit;
    logic        retry_hit;
    logic [16:0] rem_sub;
    logic [15:0] del_add;
    logic [16:0] rem_back;
    logic        rem_sub_pos;
    logic        rem_back_pos;
    logic [3:0]  idx_inc;
    logic [3:0]  len_lo;
    shfr_cmd_t   cmd_c;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign rc_inc       = retry_reg + 4'd1;
    assign limit        = (max_retries == 4'd0) ? 4'd1 : max_retries;
    assign retry_hit    = (rc_inc >= limit);
    assign rem_sub      = rem_reg - {13'd0, size_reg};
    assign del_add      = del_reg + {12'd0, size_reg};
    assign rem_back     = rem_sub + {1'b0, del_add};
    assign rem_sub_pos  = !rem_sub[16] && (rem_sub != 17'd0);
    assign rem_back_pos = !rem_back[16] && (rem_back != 17'd0);
    assign idx_inc      = idx_reg + 4'd1;
    assign len_lo       = rx_byte[3:0];

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        retry_next = retry_reg;
        rem_next   = rem_reg;
        del_next   = del_reg;
        store_we   = 1'b0;
        cmd_c      = '0;

        unique case (req_type)
            REQ_START: begin
                rem_next   = {1'b0, expected_len};
                del_next   = 16'd0;
                retry_next = 4'd0;
                size_next  = 4'd0;
                idx_next   = 4'd0;
                xor_next   = 8'd0;
                if (expected_len == 16'd0) begin
                    cmd_c.fin_en   = 1'b1;
                    cmd_c.fin_kind = KIND_DONE;
                    phase_next     = PH_IDLE;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            REQ_BYTE: begin
                unique case (phase_reg)
                    PH_TYPE: begin
                        if (rx_byte == TOK_SYNC || rx_byte == TOK_SYNC_OFF) begin
                            cmd_c.fin_en   = 1'b1;
                            cmd_c.fin_kind = KIND_SYNC;
                            cmd_c.fin_val  = rx_byte;
                            phase_next     = PH_IDLE;
                        end else begin
                            type_next  = rx_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (rx_byte[7:4] != len_lo) begin
                            cmd_c.fin_en   = 1'b1;
                            cmd_c.fin_kind = KIND_FAIL;
                            phase_next     = PH_IDLE;
                        end else if (len_lo > 4'(FRAME_MAX)) begin
                            cmd_c.rep_en   = 1'b1;
                            cmd_c.rep_val  = TOK_NAK;
                            cmd_c.fin_en   = 1'b1;
                            cmd_c.fin_kind = KIND_FAIL;
                            phase_next     = PH_IDLE;
                        end else begin
                            size_next  = len_lo;
                            idx_next   = 4'd0;
                            xor_next   = 8'd0;
                            phase_next = (len_lo != 4'd0) ? PH_DATA : PH_CHECK;
                        end
                    end
                    PH_DATA: begin
                        store_we = (idx_reg < 4'(FRAME_MAX));
                        xor_next = xor_reg ^ rx_byte;
                        idx_next = idx_inc;
                        if (idx_inc >= size_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (rx_byte == xor_reg) begin
                            // Good frame: release bytes, ACK, then settle the transfer
                            cmd_c.ndata   = size_reg;
                            cmd_c.rep_en  = 1'b1;
                            cmd_c.rep_val = TOK_ACK;
                            rem_next      = rem_sub;
                            del_next      = del_add;
                            retry_next    = 4'd0;
                            if (type_reg[7:4] == FLAG_LAST) begin
                                cmd_c.fin_en = 1'b1;
                                if (type_reg[3:0] == TYPE_NOTIFY) begin
                                    rem_next = rem_back;
                                    del_next = 16'd0;
                                    if (rem_back_pos) begin
                                        cmd_c.fin_kind = KIND_RETRACT;
                                        phase_next     = PH_TYPE;
                                    end else begin
                                        cmd_c.fin_kind = KIND_FAIL;
                                        phase_next     = PH_IDLE;
                                    end
                                end else begin
                                    cmd_c.fin_kind  = KIND_DONE;
                                    cmd_c.fin_count = del_add;
                                    phase_next      = PH_IDLE;
                                end
                            end else if (rem_sub_pos) begin
                                phase_next = PH_TYPE;
                            end else begin
                                cmd_c.fin_en   = 1'b1;
                                cmd_c.fin_kind = KIND_FAIL;
                                phase_next     = PH_IDLE;
                            end
                        end else begin
                            cmd_c.rep_en  = 1'b1;
                            cmd_c.rep_val = TOK_NAK;
                            retry_next    = rc_inc;
                            if (retry_hit) begin
                                cmd_c.fin_en   = 1'b1;
                                cmd_c.fin_kind = KIND_FAIL;
                                phase_next     = PH_IDLE;
                            end else begin
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_TICK: begin
                unique case (phase_reg)
                    PH_TYPE: begin
                        // Timeout before a frame: count a retry, no NAK
                        retry_next = rc_inc;
                        if (retry_hit) begin
                            cmd_c.fin_en   = 1'b1;
                            cmd_c.fin_kind = KIND_FAIL;
                            phase_next     = PH_IDLE;
                        end else begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_LEN: begin
                        cmd_c.fin_en   = 1'b1;
                        cmd_c.fin_kind = KIND_FAIL;
                        phase_next     = PH_IDLE;
                    end
                    PH_DATA, PH_CHECK: begin
                        // Timeout inside a frame: handle as a bad checksum
                        cmd_c.rep_en  = 1'b1;
                        cmd_c.rep_val = TOK_NAK;
                        retry_next    = rc_inc;
                        if (retry_hit) begin
                            cmd_c.fin_en   = 1'b1;
                            cmd_c.fin_kind = KIND_FAIL;
                            phase_next     = PH_IDLE;
                        end else begin
                            phase_next = PH_TYPE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign cmd  = cmd_c;
    assign push = accept && (cmd_c.rep_en || cmd_c.fin_en || (cmd_c.ndata != 4'd0));

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg <= PH_IDLE;
            type_reg  <= 8'd0;
            size_reg  <= 4'd0;
            idx_reg   <= 4'd0;
            xor_reg   <= 8'd0;
            retry_reg <= 4'd0;
            rem_reg   <= 17'd0;
            del_reg   <= 16'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
            retry_reg <= retry_next;
            rem_reg   <= rem_next;
            del_reg   <= del_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept && store_we) begin
            store_reg[idx_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    for (genvar i = 0; i < FRAME_MAX; i++) begin : g_flat
        assign frame_data[i*8 +: 8] = store_reg[i];
    end

endmodule

[rtl/shfr_queue.sv]
// Small descriptor queue between the parser and the result emitter.
// Generic width and depth; no package dependency.
module shfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rstn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty     = (count_reg == CNT_W'(0));
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/shfr_back.sv]
// Result emitter back end: expands the descriptor at the queue head into
// result transactions, one per cycle unless out_ready stalls the output,
// through a registered output stage. Depends on shfr_pkg.
module shfr_back #(
    parameter int FRAME_MAX = 8
) (
    input  logic                     clk,
    input  logic                     rstn,
    input  logic                     head_valid,
    input  shfr_pkg::shfr_cmd_t      head_cmd,
    input  logic [FRAME_MAX*8-1:0]   head_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_kind,
    output logic [7:0]               out_value,
    output logic [15:0]              out_count,
    output logic                     out_last
);
    import shfr_pkg::*;

    localparam int IDX_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]  stage_reg;
    logic [3:0]  pos_reg;
    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  value_reg;
    logic [15:0] count_reg;
    logic        last_reg;

    logic        slot_free;
    logic        emit;
    logic        cur_data;
    logic        cur_rep;
    logic        cur_last;
    logic [3:0]  pos_inc;
    logic [2:0]  cur_kind;
    logic [7:0]  cur_value;
    logic [15:0] cur_count;

    assign slot_free = !valid_reg || out_ready;
    assign emit      = head_valid && slot_free;
    assign pos_inc   = pos_reg + 4'd1;

    assign cur_data = (stage_reg == ST_DATA) && (pos_reg < head_cmd.ndata);
    assign cur_rep  = !cur_data && (stage_reg != ST_FIN) && head_cmd.rep_en;

    always_comb begin
        if (cur_data) begin
            cur_kind  = KIND_DATA;
            cur_value = head_data[8*pos_reg[IDX_W-1:0] +: 8];
            cur_count = 16'd0;
            cur_last  = (pos_inc == head_cmd.ndata) && !head_cmd.rep_en && !head_cmd.fin_en;
        end else if (cur_rep) begin
            cur_kind  = KIND_REPLY;
            cur_value = head_cmd.rep_val;
            cur_count = 16'd0;
            cur_last  = !head_cmd.fin_en;
        end else begin
            cur_kind  = head_cmd.fin_kind;
            cur_value = head_cmd.fin_val;
            cur_count = head_cmd.fin_count;
            cur_last  = 1'b1;
        end
    end

    assign pop = emit && cur_last;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            stage_reg <= ST_DATA;
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
            if (emit) begin
                if (cur_last) begin
                    stage_reg <= ST_DATA;
                    pos_reg   <= 4'd0;
                end else if (cur_data) begin
                    pos_reg <= pos_inc;
                end else begin
                    stage_reg <= ST_FIN;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (emit) begin
            kind_reg  <= cur_kind;
            value_reg <= cur_value;
            count_reg <= cur_count;
            last_reg  <= cur_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

endmodule
